// ===== rtl/mmsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor mode controller package
// Mode and event codes, stream packing widths and the mode transition table.
// ----------------------------------------------------------------------------
package mmsm_pkg;

	localparam int TRIP_W   = 3;
	localparam int SPEED_W  = 16;
	localparam int BUTTON_W = 5;
	localparam int MODE_W   = 3;

	// Input request packing, lowest bit first
	localparam int IN_BITS   = TRIP_W + 3 + SPEED_W + 1 + BUTTON_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// Result packing, lowest bit first
	localparam int OUT_BITS   = MODE_W + SPEED_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOP   = 3'd0,
		MODE_CLOSED = 3'd1,
		MODE_OPEN   = 3'd2,
		MODE_GOTO   = 3'd3,
		MODE_PID    = 3'd4,
		MODE_FAULT  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EV_STOP   = 3'd0,
		EV_CLOSED = 3'd1,
		EV_OPEN   = 3'd2,
		EV_GOTO   = 3'd3,
		EV_PID    = 3'd4,
		EV_FAULT  = 3'd5
	} event_t;

	// Next mode for one event; an ignored event returns the current mode.
	// No entry maps a mode onto itself, so a change of code marks a transition.
	function automatic mode_t mode_next(input mode_t cur, input event_t ev);
		mode_t nx;
		nx = cur;
		case (ev)
			EV_STOP: begin
				if (cur inside {MODE_CLOSED, MODE_OPEN, MODE_GOTO, MODE_PID})
					nx = MODE_STOP;
			end
			EV_CLOSED: begin
				if (cur inside {MODE_STOP, MODE_OPEN})
					nx = MODE_CLOSED;
			end
			EV_OPEN: begin
				if (cur inside {MODE_STOP, MODE_CLOSED})
					nx = MODE_OPEN;
			end
			EV_GOTO: begin
				if (cur == MODE_STOP)
					nx = MODE_GOTO;
			end
			EV_PID: begin
				if (cur == MODE_STOP)
					nx = MODE_PID;
			end
			EV_FAULT: begin
				if (cur inside {MODE_STOP, MODE_CLOSED, MODE_OPEN, MODE_GOTO, MODE_PID})
					nx = MODE_FAULT;
			end
			default: nx = cur;
		endcase
		return nx;
	endfunction

endpackage

// ===== rtl/motor_mode_state_machine_top.sv =====
// ----------------------------------------------------------------------------
// Motor mode controller
// Six-mode controller (stop, closed loop, open loop, go to start, parameter
// identification, fault) driven by one service tick per stream request.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one service tick and produces exactly
// one result on the master stream. The block takes one request per clock
// cycle while the master side does not stall; a request is held in the
// input register, then passes through the mode logic into the result
// register, and the mode, speed reference and pending latches update in
// the cycle the request leaves the input register. The pace is set by
// the mode/latch state feedback, which closes through a short cascade of
// transition table lookups. Stalls on the master side hold the result
// register and then the input register; nothing is dropped. Trips force
// fault, which only reset leaves; a pending stop request otherwise wins;
// else the command, start, go-to-start done and the five button edges are
// applied in that order. Entering stop or fault zeroes the speed reference,
// and entering parameter identification raises param_est_start for one
// result.
// ----------------------------------------------------------------------------
module motor_mode_state_machine_top
	import mmsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [2:0] trip_levels, [3] stop_request, [4] start_request,
	// [5] command_valid, [21:6] speed_command, [22] gotostart_done,
	// [27:23] button_edges, upper bits zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] mode, [18:3] speed_reference, [19] param_est_start,
	// upper bits zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// Input register stage
	logic                  valid_s1;
	logic [IN_BITS-1:0]    data_s1;

	// Controller state
	mode_t                 mode_q;
	logic [SPEED_W-1:0]    ref_speed_q;
	logic                  stop_pend_q;
	logic                  start_pend_q;
	logic                  cmd_pend_q;
	logic [BUTTON_W-1:0]   btn_pend_q;

	// Result register
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	logic                  advance;

	// Unpacked request fields
	logic [TRIP_W-1:0]     trip_levels;
	logic                  stop_request;
	logic                  start_request;
	logic                  command_valid;
	logic signed [SPEED_W-1:0] speed_command;
	logic                  gotostart_done;
	logic [BUTTON_W-1:0]   button_edges;

	// Next-state values
	logic                  stop_p;
	logic                  start_p;
	logic                  cmd_p;
	logic [BUTTON_W-1:0]   btn_p;
	mode_t                 mode_c [0:8];
	logic                  clr_ref;
	logic                  pid_pulse;
	mode_t                 mode_d;
	logic [SPEED_W-1:0]    ref_speed_d;
	logic                  stop_pend_d;
	logic                  start_pend_d;
	logic                  cmd_pend_d;
	logic [BUTTON_W-1:0]   btn_pend_d;
	logic                  load_cmd;

	// Move the stage forward when the result register is free or emptying
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign trip_levels    = data_s1[2:0];
	assign stop_request   = data_s1[3];
	assign start_request  = data_s1[4];
	assign command_valid  = data_s1[5];
	assign speed_command  = data_s1[21:6];
	assign gotostart_done = data_s1[22];
	assign button_edges   = data_s1[27:23];

	// Latch new pulses first; every branch sees the ORed latches
	assign stop_p  = stop_pend_q | stop_request;
	assign start_p = start_pend_q | start_request;
	assign cmd_p   = cmd_pend_q | command_valid;
	assign btn_p   = btn_pend_q | button_edges;

	// Event cascade: trip, stop, start, go-to-start done, then each button in
	// bit order. Each step sees the mode the previous one left.
	always_comb begin
		mode_c[0] = mode_q;
		mode_c[1] = mode_q;
		mode_c[2] = mode_q;
		mode_c[3] = mode_q;
		mode_c[4] = mode_q;
		mode_c[5] = mode_q;
		mode_c[6] = mode_q;
		mode_c[7] = mode_q;
		mode_c[8] = mode_q;
		load_cmd     = 1'b0;
		stop_pend_d  = stop_p;
		start_pend_d = start_p;
		cmd_pend_d   = cmd_p;
		btn_pend_d   = btn_p;
		if (trip_levels != '0) begin
			// Fault: keep every latch as it stands
			mode_c[0] = mode_next(mode_q, EV_FAULT);
			for (int i = 1; i < 9; i++)
				mode_c[i] = mode_c[0];
		end else if (stop_p) begin
			// Stop request: drop the stop and start latches only
			stop_pend_d  = 1'b0;
			start_pend_d = 1'b0;
			mode_c[0]    = mode_next(mode_q, EV_STOP);
			for (int i = 1; i < 9; i++)
				mode_c[i] = mode_c[0];
		end else begin
			load_cmd     = cmd_p;
			cmd_pend_d   = 1'b0;
			start_pend_d = 1'b0;
			btn_pend_d   = '0;
			mode_c[0] = start_p ? mode_next(mode_q, EV_CLOSED) : mode_q;
			mode_c[1] = gotostart_done ? mode_next(mode_c[0], EV_STOP) : mode_c[0];
			mode_c[2] = btn_p[0] ? mode_next(mode_c[1], EV_STOP) : mode_c[1];
			mode_c[3] = btn_p[1] ? mode_next(mode_c[2], EV_PID) : mode_c[2];
			mode_c[4] = btn_p[2] ? mode_next(mode_c[3], EV_CLOSED) : mode_c[3];
			mode_c[5] = btn_p[3] ? mode_next(mode_c[4], EV_OPEN) : mode_c[4];
			mode_c[6] = btn_p[4] ? mode_next(mode_c[5], EV_GOTO) : mode_c[5];
			mode_c[8] = mode_c[6];
		end
	end

	// Transitions into stop, fault or parameter id along the cascade
	always_comb begin
		mode_t prev;
		clr_ref   = 1'b0;
		pid_pulse = 1'b0;
		prev      = mode_q;
		for (int i = 0; i < 7; i++) begin
			if (mode_c[i] != prev) begin
				if (mode_c[i] == MODE_STOP || mode_c[i] == MODE_FAULT)
					clr_ref = 1'b1;
				if (mode_c[i] == MODE_PID)
					pid_pulse = 1'b1;
			end
			prev = mode_c[i];
		end
	end

	// Command load comes first in the tick, so a later clear wins
	assign mode_d      = mode_c[8];
	assign ref_speed_d = clr_ref ? '0 : (load_cmd ? speed_command : ref_speed_q);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			data_s1 <= s_tdata[IN_BITS-1:0];
	end

	// Controller state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STOP;
			ref_speed_q  <= '0;
			stop_pend_q  <= 1'b0;
			start_pend_q <= 1'b0;
			cmd_pend_q   <= 1'b0;
			btn_pend_q   <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			ref_speed_q  <= ref_speed_d;
			stop_pend_q  <= stop_pend_d;
			start_pend_q <= start_pend_d;
			cmd_pend_q   <= cmd_pend_d;
			btn_pend_q   <= btn_pend_d;
		end
	end

	// Result register: hold while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {pid_pulse, ref_speed_d, mode_d};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_data_q};

endmodule

// ===== test/mode_tick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mode result checker
// Follows both streams of the mode controller, predicts the result of every
// accepted tick and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module mode_tick_checker
	import mmsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    results_seen,
	output int                    fail_count
);

	localparam int BTN_STOP   = 0;
	localparam int BTN_PID    = 1;
	localparam int BTN_CLOSED = 2;
	localparam int BTN_OPEN   = 3;
	localparam int BTN_GOTO   = 4;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [BUTTON_W-1:0] buttons;
		logic                goto_done;
		logic [SPEED_W-1:0]  speed;
		logic                cmd_valid;
		logic                start_req;
		logic                stop_req;
		logic [TRIP_W-1:0]   trips;
	} tick_t;

	typedef struct packed {
		logic               pid_start;
		logic [SPEED_W-1:0] speed;
		mode_t              mode;
	} mode_result_t;

	mode_t               cur_mode;
	logic [SPEED_W-1:0]  ref_speed;
	logic                stop_latch;
	logic                start_latch;
	logic                cmd_latch;
	logic [BUTTON_W-1:0] button_latch;
	logic                pid_pulse;

	mode_result_t results_due[$];
	mode_result_t want;
	mode_result_t got;
	tick_t        req;
	int           mismatches;

	// Mode that one event leads to; an event with no transition keeps the mode.
	function automatic mode_t mode_after(input mode_t m, input event_t ev);
		mode_t nx;
		nx = m;
		case (m)
			MODE_STOP: begin
				case (ev)
					EV_CLOSED: nx = MODE_CLOSED;
					EV_OPEN:   nx = MODE_OPEN;
					EV_GOTO:   nx = MODE_GOTO;
					EV_PID:    nx = MODE_PID;
					EV_FAULT:  nx = MODE_FAULT;
					default:   nx = m;
				endcase
			end
			MODE_CLOSED: begin
				if (ev == EV_STOP) nx = MODE_STOP;
				else if (ev == EV_OPEN) nx = MODE_OPEN;
				else if (ev == EV_FAULT) nx = MODE_FAULT;
			end
			MODE_OPEN: begin
				if (ev == EV_STOP) nx = MODE_STOP;
				else if (ev == EV_CLOSED) nx = MODE_CLOSED;
				else if (ev == EV_FAULT) nx = MODE_FAULT;
			end
			MODE_GOTO, MODE_PID: begin
				if (ev == EV_STOP) nx = MODE_STOP;
				else if (ev == EV_FAULT) nx = MODE_FAULT;
			end
			default: nx = m;
		endcase
		return nx;
	endfunction

	task automatic fire(input event_t ev);
		mode_t nx;
		nx = mode_after(cur_mode, ev);
		if (nx != cur_mode) begin
			cur_mode = nx;
			if (nx == MODE_STOP || nx == MODE_FAULT) ref_speed = '0;
			if (nx == MODE_PID) pid_pulse = 1'b1;
		end
	endtask

	task automatic predict_tick(input tick_t t, output mode_result_t r);
		logic [BUTTON_W-1:0] btn;
		pid_pulse = 1'b0;
		stop_latch = stop_latch | t.stop_req;
		start_latch = start_latch | t.start_req;
		cmd_latch = cmd_latch | t.cmd_valid;
		button_latch = button_latch | t.buttons;
		if (t.trips != '0) begin
			fire(EV_FAULT);
		end else if (stop_latch) begin
			stop_latch = 1'b0;
			start_latch = 1'b0;
			fire(EV_STOP);
		end else begin
			if (cmd_latch) begin
				cmd_latch = 1'b0;
				ref_speed = t.speed;
			end
			if (start_latch) begin
				start_latch = 1'b0;
				fire(EV_CLOSED);
			end
			if (t.goto_done) fire(EV_STOP);
			btn = button_latch;
			button_latch = '0;
			if (btn[BTN_STOP]) fire(EV_STOP);
			if (btn[BTN_PID]) fire(EV_PID);
			if (btn[BTN_CLOSED]) fire(EV_CLOSED);
			if (btn[BTN_OPEN]) fire(EV_OPEN);
			if (btn[BTN_GOTO]) fire(EV_GOTO);
		end
		r.mode = cur_mode;
		r.speed = ref_speed;
		r.pid_start = pid_pulse;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_STOP;
			ref_speed = '0;
			stop_latch = 1'b0;
			start_latch = 1'b0;
			cmd_latch = 1'b0;
			button_latch = '0;
			pid_pulse = 1'b0;
			results_due.delete();
			mismatches = 0;
			results_seen <= 0;
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				req = s_tdata[$bits(tick_t)-1:0];
				predict_tick(req, want);
				results_due.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(mode_result_t)-1:0];
				results_seen <= results_seen + 1;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d arrived with no tick waiting:",
							results_seen, " mode %0d speed %0d pid %0b",
							got.mode, $signed(got.speed), got.pid_start);
				end else begin
					want = results_due.pop_front();
					if (got.mode !== want.mode || got.speed !== want.speed ||
							got.pid_start !== want.pid_start) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected mode %0d speed %0d pid %0b,",
								results_seen, want.mode, $signed(want.speed),
								want.pid_start, " got mode %0d speed %0d pid %0b",
								got.mode, $signed(got.speed), got.pid_start);
					end
				end
			end
			// Predictions still waiting count against the run until they are met.
			fail_count <= mismatches + results_due.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor mode controller testbench
// Sends directed and random service ticks through the controller under
// changing back pressure; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
	import mmsm_pkg::*;

	// Trip level masks
	localparam logic [TRIP_W-1:0] TRIP_OC  = 3'b001;
	localparam logic [TRIP_W-1:0] TRIP_OT  = 3'b010;
	localparam logic [TRIP_W-1:0] TRIP_OV  = 3'b100;
	localparam logic [TRIP_W-1:0] TRIP_ALL = 3'b111;

	// Button edge masks
	localparam logic [BUTTON_W-1:0] BTN_NONE   = 5'b00000;
	localparam logic [BUTTON_W-1:0] BTN_STOP   = 5'b00001;
	localparam logic [BUTTON_W-1:0] BTN_PID    = 5'b00010;
	localparam logic [BUTTON_W-1:0] BTN_CLOSED = 5'b00100;
	localparam logic [BUTTON_W-1:0] BTN_OPEN   = 5'b01000;
	localparam logic [BUTTON_W-1:0] BTN_GOTO   = 5'b10000;
	localparam logic [BUTTON_W-1:0] BTN_ALL    = 5'b11111;

	localparam int TICKS_PER_PHASE = 400;
	localparam int FAULT_TAIL      = 20;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 200000;

	typedef struct packed {
		logic [BUTTON_W-1:0] buttons;
		logic                goto_done;
		logic [SPEED_W-1:0]  speed;
		logic                cmd_valid;
		logic                start_req;
		logic                stop_req;
		logic [TRIP_W-1:0]   trips;
	} tick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int send_gap_pct;
	int take_gap_pct;
	int ticks_sent;
	int results_seen;
	int fail_count;
	int cycle_count = 0;

	motor_mode_state_machine_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mode_tick_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.results_seen (results_seen),
		.fail_count   (fail_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random; the rate follows the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= take_gap_pct);
	end

	// Hard stop for a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic tick_t make_tick(input logic [TRIP_W-1:0] trips, input logic stop_req,
			input logic start_req, input logic cmd_valid, input logic [SPEED_W-1:0] speed,
			input logic goto_done, input logic [BUTTON_W-1:0] buttons);
		tick_t t;
		t.trips = trips;
		t.stop_req = stop_req;
		t.start_req = start_req;
		t.cmd_valid = cmd_valid;
		t.speed = speed;
		t.goto_done = goto_done;
		t.buttons = buttons;
		return t;
	endfunction

	// Mostly well-formed traffic: trips only when asked for (fault is sticky
	// until reset), stop and go-to-start done rare enough that the running
	// modes get time to move around.
	function automatic tick_t random_tick(input int trip_pct);
		tick_t t;
		t = '0;
		if ($urandom_range(99) < trip_pct) t.trips = TRIP_W'($urandom_range(7, 1));
		t.stop_req = ($urandom_range(99) < 8);
		t.start_req = ($urandom_range(99) < 20);
		t.cmd_valid = ($urandom_range(99) < 40);
		case ($urandom_range(7))
			0: t.speed = 16'h7FFF;
			1: t.speed = 16'h8000;
			default: t.speed = SPEED_W'($urandom);
		endcase
		t.goto_done = ($urandom_range(99) < 6);
		for (int b = 0; b < BUTTON_W; b++)
			t.buttons[b] = ($urandom_range(99) < 12);
		return t;
	endfunction

	// Offer one request and hold it until the block takes it.
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - $bits(tick_t)){1'b0}}, t};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		ticks_sent = 0;
		send_gap_pct = 16;
		take_gap_pct = 78;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the transition tables, no trips yet.
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		// load the largest speed, then start into closed loop
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b1, 16'h7FFF, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_OPEN));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_CLOSED));
		// stop wins over start and command; the command stays latched
		send_tick(make_tick('0, 1'b1, 1'b1, 1'b1, 16'h8000, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h8000, 1'b0, BTN_NONE));
		// stop while already stopped must keep the speed reference
		send_tick(make_tick('0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_PID));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		// go-to-start done acts as a stop
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_GOTO));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_STOP));
		// every button at once, from stop and from parameter id
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0, BTN_ALL));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0001, 1'b1, BTN_ALL));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_STOP));
		// chained events in one tick: start then open
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, BTN_OPEN));
		// command loaded, then cleared by the done stop in the same tick
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b1, 16'h8001, 1'b1, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b1, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_GOTO));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b1, 16'h1234, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, BTN_NONE));

		// Random traffic under three back pressure mixes.
		repeat (TICKS_PER_PHASE) send_tick(random_tick(0));
		send_gap_pct = 78;
		take_gap_pct = 16;
		repeat (TICKS_PER_PHASE) send_tick(random_tick(0));
		send_gap_pct = 0;
		take_gap_pct = 0;
		repeat (TICKS_PER_PHASE) send_tick(random_tick(0));

		// Fault tail: once tripped, only reset leaves fault, so do it last.
		send_tick(make_tick(TRIP_OC, 1'b1, 1'b1, 1'b1, 16'h1234, 1'b0, BTN_ALL));
		send_tick(make_tick(TRIP_OT, 1'b0, 1'b0, 1'b1, 16'h5555, 1'b0, BTN_NONE));
		send_tick(make_tick(TRIP_OV, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, BTN_NONE));
		send_tick(make_tick(TRIP_ALL, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		// latches drain: stop first, then command loads the speed in fault
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b0, 1'b0, 16'hA5A5, 1'b0, BTN_NONE));
		send_tick(make_tick('0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b1, BTN_ALL));
		repeat (FAULT_TAIL) send_tick(random_tick(25));
		s_tvalid <= 1'b0;

		// Drain: every request owes one result.
		while (results_seen != ticks_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mmsm_pkg.sv
rtl/motor_mode_state_machine_top.sv
test/mode_tick_checker.sv
test/testbench.sv
